[design/vfc_pkg.sv]
package vfc_pkg;

    // Chunk geometry. The coordinate fields are four bits wide, so the chunk
    // edge is a power of two and addresses are plain bit concatenations.
    localparam int CHUNK_EDGE  = 16;
    localparam int COORD_W     = 4;
    localparam int SIDE_W      = 3;
    localparam int NUM_SIDES   = 6;
    localparam int CUBE_AW     = 3 * COORD_W;
    localparam int PLANE_AW    = SIDE_W + 2 * COORD_W;
    localparam int CUBE_DEPTH  = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
    localparam int PLANE_DEPTH = NUM_SIDES * CHUNK_EDGE * CHUNK_EDGE;
    localparam logic [COORD_W-1:0] COORD_LAST = COORD_W'(CHUNK_EDGE - 1);

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input operation codes.
    localparam logic [1:0] OP_WR_VOX  = 2'd0;
    localparam logic [1:0] OP_WR_EDGE = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;

    // Neighbor sides, also the bit order of the face mask.
    localparam logic [SIDE_W-1:0] SIDE_NX = 3'd0;
    localparam logic [SIDE_W-1:0] SIDE_PX = 3'd1;
    localparam logic [SIDE_W-1:0] SIDE_NY = 3'd2;
    localparam logic [SIDE_W-1:0] SIDE_PY = 3'd3;
    localparam logic [SIDE_W-1:0] SIDE_NZ = 3'd4;
    localparam logic [SIDE_W-1:0] SIDE_PZ = 3'd5;

    // Command kinds produced by the front.
    localparam logic [1:0] CMD_WR_VOX     = 2'd0;
    localparam logic [1:0] CMD_WR_EDGE    = 2'd1;
    localparam logic [1:0] CMD_QUERY      = 2'd2;
    localparam logic [1:0] CMD_QUERY_NULL = 2'd3;

    typedef struct packed {
        logic [1:0]          kind;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  z;
        logic [PLANE_AW-1:0] plane_addr;
        logic                vis;
    } vfc_cmd_t;

    // True when a coordinate lies inside the chunk.
    function automatic logic coord_ok(input logic [COORD_W-1:0] c);
        return c <= COORD_LAST;
    endfunction

    // Edge plane address of a side: the two coordinates across the side's axis.
    function automatic logic [PLANE_AW-1:0] plane_index(
        input logic [SIDE_W-1:0]  side,
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y,
        input logic [COORD_W-1:0] z
    );
        logic [COORD_W-1:0] a;
        logic [COORD_W-1:0] b;
        case (side)
            SIDE_NX, SIDE_PX:
            begin
                a = y;
                b = z;
            end
            SIDE_NY, SIDE_PY:
            begin
                a = x;
                b = z;
            end
            default:
            begin
                a = x;
                b = y;
            end
        endcase
        return {side, a, b};
    endfunction

endpackage

[design/vfc_front.sv]
module vfc_front
    import vfc_pkg::*;
(
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic [COORD_W-1:0] pos_x,
    input  logic [COORD_W-1:0] pos_y,
    input  logic [COORD_W-1:0] pos_z,
    input  logic [SIDE_W-1:0]  side,
    input  logic               visible_in,
    input  logic               q_full,
    output logic               push,
    output vfc_cmd_t           cmd
);

    logic                     xyz_ok;
    logic [PLANE_AW-1:0]      plane_addr;
    logic [COORD_W-1:0]       plane_a;
    logic [COORD_W-1:0]       plane_b;
    logic                     keep;

    // The queue alone holds back the input.
    assign in_stall = q_full;

    assign xyz_ok     = coord_ok(pos_x) && coord_ok(pos_y) && coord_ok(pos_z);
    assign plane_addr = plane_index(side, pos_x, pos_y, pos_z);
    assign plane_a    = plane_addr[2*COORD_W-1:COORD_W];
    assign plane_b    = plane_addr[COORD_W-1:0];

    // Classify the item; writes that land nowhere and unused codes are dropped.
    always_comb
    begin
        keep           = 1'b0;
        cmd.kind       = CMD_WR_VOX;
        cmd.x          = pos_x;
        cmd.y          = pos_y;
        cmd.z          = pos_z;
        cmd.plane_addr = plane_addr;
        cmd.vis        = visible_in;
        case (op)
            OP_WR_VOX:
            begin
                keep     = xyz_ok;
                cmd.kind = CMD_WR_VOX;
            end
            OP_WR_EDGE:
            begin
                keep     = (side <= SIDE_PZ) && coord_ok(plane_a) && coord_ok(plane_b);
                cmd.kind = CMD_WR_EDGE;
            end
            OP_QUERY:
            begin
                keep     = 1'b1;
                cmd.kind = xyz_ok ? CMD_QUERY : CMD_QUERY_NULL;
            end
            default:
            begin
                keep     = 1'b0;
                cmd.kind = CMD_WR_VOX;
            end
        endcase
    end

    // A command enters the queue on every kept transfer.
    assign push = in_valid && !q_full && keep;

endmodule

[design/vfc_queue.sv]
module vfc_queue
    import vfc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  vfc_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output vfc_cmd_t head_cmd
);

    vfc_cmd_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = entry_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && head_valid;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[design/vfc_back.sv]
module vfc_back
    import vfc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  vfc_cmd_t             cmd,
    output logic                 cmd_pop,
    input  logic [NUM_SIDES-1:0] nbr_present,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [NUM_SIDES-1:0] face_mask,
    output logic                 voxel_visible
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam logic [SIDE_W-1:0] LAST_STEP = SIDE_W'(NUM_SIDES);

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [SIDE_W-1:0]     idx_reg;
    logic [SIDE_W-1:0]     idx_next;
    logic [COORD_W-1:0]    x_reg;
    logic [COORD_W-1:0]    y_reg;
    logic [COORD_W-1:0]    z_reg;
    logic [NUM_SIDES-1:0]  mask_reg;
    logic [NUM_SIDES-1:0]  mask_next;
    logic                  self_reg;
    logic                  self_next;
    logic                  border_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [NUM_SIDES-1:0]  face_mask_reg;
    logic                  voxel_visible_reg;

    logic                  vox_mem [CUBE_DEPTH];
    logic                  edge_mem [PLANE_DEPTH];
    logic                  vox_rd_reg;
    logic                  edge_rd_reg;
    logic                  vox_we;
    logic                  edge_we;
    logic [CUBE_AW-1:0]    vox_raddr;
    logic [PLANE_AW-1:0]   edge_raddr;

    logic                  start;
    logic                  out_free;
    logic                  out_load;
    logic [NUM_SIDES-1:0]  res_mask;
    logic                  res_vis;

    logic [SIDE_W-1:0]     face;
    logic [SIDE_W-1:0]     ret_face;
    logic [COORD_W-1:0]    axis_c;
    logic [COORD_W-1:0]    step_c;
    logic                  face_border;
    logic [COORD_W-1:0]    nx;
    logic [COORD_W-1:0]    ny;
    logic [COORD_W-1:0]    nz;
    logic                  face_bit;

    assign out_free = !out_valid_reg || !out_stall;

    // Neighbor of the face being issued: step one voxel along its axis.
    assign face     = idx_reg;
    assign ret_face = idx_reg - 1'b1;
    always_comb
    begin
        case (face)
            SIDE_NX, SIDE_PX: axis_c = x_reg;
            SIDE_NY, SIDE_PY: axis_c = y_reg;
            default:          axis_c = z_reg;
        endcase
        face_border = face[0] ? (axis_c == COORD_LAST) : (axis_c == '0);
        step_c      = face[0] ? axis_c + 1'b1 : axis_c - 1'b1;
        nx = x_reg;
        ny = y_reg;
        nz = z_reg;
        case (face)
            SIDE_NX, SIDE_PX: nx = step_c;
            SIDE_NY, SIDE_PY: ny = step_c;
            default:          nz = step_c;
        endcase
    end

    // Read addresses: the queried voxel at start, one face per cycle after.
    assign start      = (state_reg == ST_IDLE) && cmd_valid && (cmd.kind == CMD_QUERY);
    assign vox_raddr  = start ? {cmd.x, cmd.y, cmd.z} : {nx, ny, nz};
    assign edge_raddr = plane_index(face, x_reg, y_reg, z_reg);

    // Face drawn if the touching voxel, in or across the edge, is clear or absent.
    assign face_bit = border_reg ? (!nbr_present[ret_face] || !edge_rd_reg) : !vox_rd_reg;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        mask_next  = mask_reg;
        self_next  = self_reg;
        cmd_pop    = 1'b0;
        vox_we     = 1'b0;
        edge_we    = 1'b0;
        out_load   = 1'b0;
        res_mask   = mask_reg & {NUM_SIDES{self_reg}};
        res_vis    = self_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        CMD_WR_VOX:
                        begin
                            vox_we  = 1'b1;
                            cmd_pop = 1'b1;
                        end
                        CMD_WR_EDGE:
                        begin
                            edge_we = 1'b1;
                            cmd_pop = 1'b1;
                        end
                        CMD_QUERY:
                        begin
                            cmd_pop    = 1'b1;
                            idx_next   = '0;
                            state_next = ST_RUN;
                        end
                        default:
                        begin
                            res_mask = '0;
                            res_vis  = 1'b0;
                            if (out_free)
                            begin
                                out_load = 1'b1;
                                cmd_pop  = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                if (idx_reg == '0)
                begin
                    self_next = vox_rd_reg;
                end
                else
                begin
                    mask_next[ret_face] = face_bit;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_STEP)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Query context and result registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= cmd.x;
            y_reg <= cmd.y;
            z_reg <= cmd.z;
        end
        mask_reg   <= mask_next;
        self_reg   <= self_next;
        border_reg <= face_border;
        if (out_load)
        begin
            face_mask_reg     <= res_mask;
            voxel_visible_reg <= res_vis;
        end
    end

    // Chunk voxel memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (vox_we)
        begin
            vox_mem[{cmd.x, cmd.y, cmd.z}] <= cmd.vis;
        end
        vox_rd_reg <= vox_mem[vox_raddr];
    end

    // Neighbor edge plane memory.
    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[cmd.plane_addr] <= cmd.vis;
        end
        edge_rd_reg <= edge_mem[edge_raddr];
    end

    assign out_valid     = out_valid_reg;
    assign face_mask     = face_mask_reg;
    assign voxel_visible = voxel_visible_reg;

    // A command is only consumed when the queue offers one.
    assert property (@(posedge clk) disable iff (!rst_n) cmd_pop |-> cmd_valid)
        else $error("command popped from an empty queue");

    // The face counter stays within the six faces plus the self read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (idx_reg <= LAST_STEP))
        else $error("face counter out of range");

    // A hidden voxel never reports faces.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !voxel_visible_reg) |-> (face_mask_reg == '0))
        else $error("faces reported for a hidden voxel");

    // A finished query waiting for the output never loses its result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !out_free) |=> (state_reg == ST_DONE))
        else $error("query result dropped while output busy");

endmodule

[design/voxel_face_culling.sv]
// Hidden-face culling for one 16x16x16 voxel chunk. Chunk and neighbor edge
// voxel writes are done in the back end's idle state; a query runs through run
// and done states, because the chunk memory and the edge plane memory each have
// a single registered read port and the sequencer reads the voxel itself and
// then one face per cycle. A two-entry command queue sits between the input
// decoder and the sequencer, so input transfers continue while a query runs or
// a result waits on a stalled output, until the queue fills. Out-of-chunk
// writes, neighbor writes to an unknown side and the unused op code are dropped
// without a result. Stored bits read as undefined until written, and
// neighbor_present must only be changed while the block is idle.
module voxel_face_culling
    import vfc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [NUM_SIDES-1:0] cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           op,
    input  logic [COORD_W-1:0]   pos_x,
    input  logic [COORD_W-1:0]   pos_y,
    input  logic [COORD_W-1:0]   pos_z,
    input  logic [SIDE_W-1:0]    side,
    input  logic                 visible_in,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [NUM_SIDES-1:0] face_mask,
    output logic                 voxel_visible
);

    logic [NUM_SIDES-1:0] neighbour_present_reg;
    logic                 q_full;
    logic                 push;
    vfc_cmd_t             push_cmd;
    logic                 pop;
    logic                 head_valid;
    vfc_cmd_t             head_cmd;

    // Neighbor presence register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neighbour_present_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            neighbour_present_reg <= cfg_wr_data;
        end
    end

    // Input decode.
    vfc_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .side       (side),
        .visible_in (visible_in),
        .q_full     (q_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    // Command queue.
    vfc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Storage and query sequencer.
    vfc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (head_valid),
        .cmd           (head_cmd),
        .cmd_pop       (pop),
        .nbr_present   (neighbour_present_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .face_mask     (face_mask),
        .voxel_visible (voxel_visible)
    );

endmodule
